/* rtl/core/rolling_hash_substring_counter_assert.svh */
// Assertion macros shared by the block's RTL.
// Each macro gives one labeled concurrent assertion on clk_i with reset rst_ni.
`ifndef ROLLING_HASH_SUBSTRING_COUNTER_ASSERT_SVH
`define ROLLING_HASH_SUBSTRING_COUNTER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define RHSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RHSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rhsc_pkg.sv */
`timescale 1ns / 1ps

package rhsc_pkg;

  // Field and register widths.
  localparam int BYTE_W      = 8;
  localparam int HASH_W      = 20;
  localparam int BASE_W      = 7;
  localparam int COUNT_W     = 20;
  localparam int LEN_CFG_W   = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  localparam int MAX_PATTERN_DEFAULT = 64;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HASH_A = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HASH_B = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_POWER_A    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_POWER_B    = 3'd4;

  // Moduli and bases of the two hashes.
  localparam int unsigned MOD_A  = 1000003;
  localparam int unsigned MOD_B  = 1000033;
  localparam int unsigned BASE_A = 107;
  localparam int unsigned BASE_B = 101;

  // Reduction by reciprocal: operands stay below 2^RED_X_W, the quotient
  // estimate is at most one low, so the remainder lies below twice the modulus.
  localparam int RED_X_W   = 28;
  localparam int RECIP_W   = 29;
  localparam int RED_SHIFT = 48;
  localparam int QUOT_W    = RED_X_W + RECIP_W - RED_SHIFT;
  localparam int REM_W     = HASH_W + 1;
  localparam int DIFF_W    = HASH_W + 3;

  localparam logic [63:0] RECIP_A_FULL = (64'd1 << RED_SHIFT) / 64'(MOD_A);
  localparam logic [63:0] RECIP_B_FULL = (64'd1 << RED_SHIFT) / 64'(MOD_B);

  // Constants of one hash lane.
  typedef struct packed {
    logic [HASH_W-1:0]  modulus;
    logic [BASE_W-1:0]  base;
    logic [RECIP_W-1:0] recip;
  } rhsc_hash_const_t;

  localparam rhsc_hash_const_t HASH_A_CONST = '{
    modulus: HASH_W'(MOD_A),
    base:    BASE_W'(BASE_A),
    recip:   RECIP_A_FULL[RECIP_W-1:0]
  };
  localparam rhsc_hash_const_t HASH_B_CONST = '{
    modulus: HASH_W'(MOD_B),
    base:    BASE_W'(BASE_B),
    recip:   RECIP_B_FULL[RECIP_W-1:0]
  };

  // Step enables from the sequencer to the hash lanes.
  typedef struct packed {
    logic start;     // beat accepted
    logic fresh;     // beat opens a new text
    logic mul_leave; // leaving byte times top power
    logic red_hi;    // quotient estimate
    logic red_lo;    // remainder
    logic sub;       // remove leaving term from hash
    logic mul_base;  // shift hash by base and add entering byte
    logic fin;       // final correction into the hash register
  } rhsc_step_t;

endpackage

/* rtl/core/rolling_hash_substring_counter.sv */
`timescale 1ns / 1ps

// Counts the windows of a byte stream whose two polynomial hashes equal a
// loaded pattern's (base 107 mod 1000003 and base 101 mod 1000033).
// Input channel: one text byte per beat, with new_text marking the first byte
// of a text, which clears the window, both hashes and the count.
// Output channel: one result per input beat, the match flag of the window
// ending at that byte and the saturating count of matches in this text.
// Configuration: write pattern length, pattern hashes and top powers by index
// while the block is idle; writes take effect at once, beyond index 4 ignored.
// A result is registered in state OUT after its byte passes states LEAVE
// through FIN. A new byte is taken once the previous result is in the output
// register; the chain of two multiply-reduce steps per byte in each hash
// lane, sharing that lane's one reducer, sets this pace.
// The delay line is a memory with one write and one registered read a byte.
// Reset clears the window, counters, hashes and output valid; no clearing
// pass is needed, since only bytes of the current text are ever read.
// When the receiver stalls, the result waits in the output register and the
// next byte is still accepted and worked on up to its final step.

`include "rolling_hash_substring_counter_assert.svh"

module rolling_hash_substring_counter #(
  parameter int MAX_PATTERN = rhsc_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rhsc_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [rhsc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rhsc_pkg::BYTE_W-1:0]        text_byte_i,
  input  logic                               new_text_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               window_match_o,
  output logic [rhsc_pkg::COUNT_W-1:0]       match_count_o
);

  localparam int SlotW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LenW  = $clog2(MAX_PATTERN + 1);
  localparam int CmpW  = (LenW > rhsc_pkg::LEN_CFG_W) ? LenW : rhsc_pkg::LEN_CFG_W;
  localparam int DW    = LenW + 1;
  localparam int HashW = rhsc_pkg::HASH_W;
  localparam int CntW  = rhsc_pkg::COUNT_W;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LEAVE    = 4'd1;
  localparam logic [3:0] ST_RED1_HI  = 4'd2;
  localparam logic [3:0] ST_RED1_LO  = 4'd3;
  localparam logic [3:0] ST_SUB      = 4'd4;
  localparam logic [3:0] ST_MUL_BASE = 4'd5;
  localparam logic [3:0] ST_RED2_HI  = 4'd6;
  localparam logic [3:0] ST_RED2_LO  = 4'd7;
  localparam logic [3:0] ST_FIN      = 4'd8;
  localparam logic [3:0] ST_OUT      = 4'd9;

  logic [3:0] state_q, state_d;

  // Configuration registers.
  logic [rhsc_pkg::LEN_CFG_W-1:0] pattern_length_q;
  logic [HashW-1:0] pattern_hash_a_q;
  logic [HashW-1:0] pattern_hash_b_q;
  logic [HashW-1:0] top_power_a_q;
  logic [HashW-1:0] top_power_b_q;

  // Window bookkeeping.
  logic [SlotW-1:0] slot_q;
  logic [SlotW-1:0] wr_slot_q;
  logic [LenW-1:0]  seen_q;
  logic             leave_vld_q;
  logic             full_q;
  logic [CntW-1:0]  count_q;
  logic [rhsc_pkg::BYTE_W-1:0] byte_q;

  // Output register.
  logic             out_valid_q;
  logic             out_match_q;
  logic [CntW-1:0]  out_count_q;

  logic             accept;
  logic             out_load;
  logic [CmpW-1:0]  len_ext;
  logic [LenW-1:0]  len_eff;
  logic [SlotW-1:0] eff_slot;
  logic [LenW-1:0]  eff_seen;
  logic [LenW-1:0]  seen_next;
  logic [SlotW-1:0] slot_next;
  logic [DW-1:0]    rd_diff;
  logic [DW-1:0]    rd_wrap;
  logic [SlotW-1:0] rd_addr;
  logic [rhsc_pkg::BYTE_W-1:0] mem_rdata;
  logic [rhsc_pkg::BYTE_W-1:0] leave_byte;
  logic [HashW-1:0] hash_a;
  logic [HashW-1:0] hash_b;
  logic             match;
  logic [CntW-1:0]  count_next;
  rhsc_pkg::rhsc_step_t step;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= rhsc_pkg::LEN_CFG_W'(1);
      pattern_hash_a_q <= '0;
      pattern_hash_b_q <= '0;
      top_power_a_q    <= HashW'(1);
      top_power_b_q    <= HashW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rhsc_pkg::REG_PATTERN_LENGTH: begin
          pattern_length_q <= cfg_wdata_i[rhsc_pkg::LEN_CFG_W-1:0];
        end
        rhsc_pkg::REG_PATTERN_HASH_A: pattern_hash_a_q <= cfg_wdata_i;
        rhsc_pkg::REG_PATTERN_HASH_B: pattern_hash_b_q <= cfg_wdata_i;
        rhsc_pkg::REG_TOP_POWER_A:    top_power_a_q    <= cfg_wdata_i;
        rhsc_pkg::REG_TOP_POWER_B:    top_power_b_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Window length clamped to one through the delay line depth.
  assign len_ext = CmpW'(pattern_length_q);

  always_comb begin
    if (len_ext == '0) begin
      len_eff = LenW'(1);
    end else if (len_ext > CmpW'(MAX_PATTERN)) begin
      len_eff = LenW'(MAX_PATTERN);
    end else begin
      len_eff = len_ext[LenW-1:0];
    end
  end

  // Position of this byte; a new text starts from an empty window.
  assign eff_slot  = new_text_i ? '0 : slot_q;
  assign eff_seen  = new_text_i ? '0 : seen_q;
  assign seen_next = (eff_seen == LenW'(MAX_PATTERN)) ? eff_seen : eff_seen + LenW'(1);
  assign slot_next = (eff_slot == SlotW'(MAX_PATTERN - 1)) ? '0 : eff_slot + SlotW'(1);

  // Slot of the byte leaving the window, wrapped around the delay line.
  assign rd_diff = DW'(eff_slot) - DW'(len_eff);
  assign rd_wrap = rd_diff[DW-1] ? rd_diff + DW'(MAX_PATTERN) : rd_diff;
  assign rd_addr = rd_wrap[SlotW-1:0];

  // Byte positions and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      seen_q      <= '0;
      wr_slot_q   <= '0;
      leave_vld_q <= 1'b0;
      full_q      <= 1'b0;
      count_q     <= '0;
    end else if (accept) begin
      slot_q      <= slot_next;
      seen_q      <= seen_next;
      wr_slot_q   <= eff_slot;
      leave_vld_q <= (eff_seen >= len_eff);
      full_q      <= (seen_next >= len_eff);
      if (new_text_i) begin
        count_q <= '0;
      end
    end else if (out_load) begin
      count_q <= count_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= text_byte_i;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (accept) state_d = ST_LEAVE;
      ST_LEAVE:    state_d = ST_RED1_HI;
      ST_RED1_HI:  state_d = ST_RED1_LO;
      ST_RED1_LO:  state_d = ST_SUB;
      ST_SUB:      state_d = ST_MUL_BASE;
      ST_MUL_BASE: state_d = ST_RED2_HI;
      ST_RED2_HI:  state_d = ST_RED2_LO;
      ST_RED2_LO:  state_d = ST_FIN;
      ST_FIN:      state_d = ST_OUT;
      ST_OUT:      if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Step enables for both hash lanes.
  always_comb begin
    step.start     = accept;
    step.fresh     = new_text_i;
    step.mul_leave = (state_q == ST_LEAVE);
    step.red_hi    = (state_q == ST_RED1_HI) || (state_q == ST_RED2_HI);
    step.red_lo    = (state_q == ST_RED1_LO) || (state_q == ST_RED2_LO);
    step.sub       = (state_q == ST_SUB);
    step.mul_base  = (state_q == ST_MUL_BASE);
    step.fin       = (state_q == ST_FIN);
  end

  // Delay line: read the leaving byte on accept, store the new byte after.
  rhsc_window_mem #(
    .Depth(MAX_PATTERN)
  ) u_window_mem (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_LEAVE),
    .waddr_i (wr_slot_q),
    .wdata_i (byte_q),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  assign leave_byte = leave_vld_q ? mem_rdata : '0;

  rhsc_hash_unit u_hash_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .const_i (rhsc_pkg::HASH_A_CONST),
    .power_i (top_power_a_q),
    .leave_i (leave_byte),
    .enter_i (byte_q),
    .hash_o  (hash_a)
  );

  rhsc_hash_unit u_hash_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .const_i (rhsc_pkg::HASH_B_CONST),
    .power_i (top_power_b_q),
    .leave_i (leave_byte),
    .enter_i (byte_q),
    .hash_o  (hash_b)
  );

  // Match test and saturating count.
  assign match      = full_q && (hash_a == pattern_hash_a_q) && (hash_b == pattern_hash_b_q);
  assign count_next = (match && (count_q != rhsc_pkg::COUNT_MAX)) ? count_q + CntW'(1)
                                                                  : count_q;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_match_q <= match;
      out_count_q <= count_next;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign window_match_o = out_match_q;
  assign match_count_o  = out_count_q;

  // Checks.
  `RHSC_ASSERT_NEXT(a_accept_starts_seq, accept, state_q == ST_LEAVE,
                    "accepted beat did not start the sequence")
  `RHSC_ASSERT_NEXT(a_out_only_from_seq, (state_q != ST_OUT) && !out_valid_q,
                    !out_valid_q, "result appeared without a finished beat")
  `RHSC_ASSERT_SAME(a_hash_reduced, 1'b1,
                    (hash_a < rhsc_pkg::HASH_A_CONST.modulus) &&
                    (hash_b < rhsc_pkg::HASH_B_CONST.modulus),
                    "rolling hash left its modulus range")
  `RHSC_ASSERT_SAME(a_match_counted, out_valid_q && out_match_q, out_count_q != '0,
                    "match reported with zero count")

endmodule

/* rtl/core/rhsc_window_mem.sv */
`timescale 1ns / 1ps

module rhsc_window_mem #(
  parameter int Depth = rhsc_pkg::MAX_PATTERN_DEFAULT,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [rhsc_pkg::BYTE_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [rhsc_pkg::BYTE_W-1:0] rdata_o
);

  logic [rhsc_pkg::BYTE_W-1:0] mem_q [Depth];
  logic [rhsc_pkg::BYTE_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rhsc_hash_unit.sv */
`timescale 1ns / 1ps

module rhsc_hash_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rhsc_pkg::rhsc_step_t          step_i,
  input  rhsc_pkg::rhsc_hash_const_t    const_i,
  input  logic [rhsc_pkg::HASH_W-1:0]   power_i,
  input  logic [rhsc_pkg::BYTE_W-1:0]   leave_i,
  input  logic [rhsc_pkg::BYTE_W-1:0]   enter_i,
  output logic [rhsc_pkg::HASH_W-1:0]   hash_o
);

  localparam int HashW = rhsc_pkg::HASH_W;
  localparam int XW    = rhsc_pkg::RED_X_W;
  localparam int RW    = rhsc_pkg::RECIP_W;
  localparam int QW    = rhsc_pkg::QUOT_W;
  localparam int RemW  = rhsc_pkg::REM_W;
  localparam int DW    = rhsc_pkg::DIFF_W;
  localparam int BW    = rhsc_pkg::BYTE_W;
  localparam int BaseW = rhsc_pkg::BASE_W;

  logic [HashW-1:0] power_red_q;
  logic [XW-1:0]    x_q;
  logic [QW-1:0]    quot_q;
  logic [RemW-1:0]  rem_q;
  logic [HashW-1:0] diff_q;
  logic [HashW-1:0] hash_q;

  logic [RemW-1:0]  mod_ext;
  logic [RemW-1:0]  power_ext;
  logic [RemW-1:0]  power_sub;
  logic [HashW-1:0] power_red;
  logic [XW-1:0]    leave_prod;
  logic [XW-1:0]    base_prod;
  logic [XW+RW-1:0] recip_prod;
  logic [XW-1:0]    quot_mod;
  logic [XW-1:0]    rem_full;
  logic [DW-1:0]    diff0;
  logic [DW-1:0]    diff1;
  logic [DW-1:0]    diff2;
  logic [DW-1:0]    diff_sel;
  logic [RemW-1:0]  rem_sub;
  logic [HashW-1:0] hash_fix;

  // Top power register is 20 bits and may exceed the modulus once.
  assign mod_ext   = {1'b0, const_i.modulus};
  assign power_ext = {1'b0, power_i};
  assign power_sub = power_ext - mod_ext;
  assign power_red = (power_ext >= mod_ext) ? power_sub[HashW-1:0] : power_i;

  // Leaving byte times reduced power, and hash times base plus entering byte.
  assign leave_prod = {{(XW-BW){1'b0}}, leave_i} * {{(XW-HashW){1'b0}}, power_red_q};
  assign base_prod  = {{(XW-HashW){1'b0}}, diff_q} * {{(XW-BaseW){1'b0}}, const_i.base}
                    + {{(XW-BW){1'b0}}, enter_i};

  // Quotient estimate through the reciprocal, then the remainder.
  assign recip_prod = {{RW{1'b0}}, x_q} * {{XW{1'b0}}, const_i.recip};
  assign quot_mod   = {{(XW-QW){1'b0}}, quot_q} * {{(XW-HashW){1'b0}}, const_i.modulus};
  assign rem_full   = x_q - quot_mod;

  // Hash minus remainder; the remainder is below twice the modulus.
  assign diff0 = {3'b000, hash_q} - {2'b00, rem_q};
  assign diff1 = diff0 + {3'b000, const_i.modulus};
  assign diff2 = diff0 + {2'b00, const_i.modulus, 1'b0};

  always_comb begin
    if (!diff0[DW-1]) begin
      diff_sel = diff0;
    end else if (!diff1[DW-1]) begin
      diff_sel = diff1;
    end else begin
      diff_sel = diff2;
    end
  end

  // Final correction of the remainder into range.
  assign rem_sub  = rem_q - mod_ext;
  assign hash_fix = (rem_q >= mod_ext) ? rem_sub[HashW-1:0] : rem_q[HashW-1:0];

  // Datapath registers, loaded by sequencer step.
  always_ff @(posedge clk_i) begin
    if (step_i.start) begin
      power_red_q <= power_red;
    end
    if (step_i.mul_leave) begin
      x_q <= leave_prod;
    end else if (step_i.mul_base) begin
      x_q <= base_prod;
    end
    if (step_i.red_hi) begin
      quot_q <= recip_prod[XW+RW-1:rhsc_pkg::RED_SHIFT];
    end
    if (step_i.red_lo) begin
      rem_q <= rem_full[RemW-1:0];
    end
    if (step_i.sub) begin
      diff_q <= diff_sel[HashW-1:0];
    end
  end

  // Rolling hash state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else if (step_i.start && step_i.fresh) begin
      hash_q <= '0;
    end else if (step_i.fin) begin
      hash_q <= hash_fix;
    end
  end

  assign hash_o = hash_q;

endmodule
